### hw/rtl/vrff_pkg.sv
package vrff_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic        line_kept;
        logic [31:0] kept_total;
        logic [15:0] sample_total;
    } t_out_item;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_HASH    = 3'd1;
    localparam logic [2:0] PH_COMMENT = 3'd2;
    localparam logic [2:0] PH_HEADER  = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;

    localparam logic [1:0] CFG_CHROM = 2'd0;
    localparam logic [1:0] CFG_MIN   = 2'd1;
    localparam logic [1:0] CFG_MAX   = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [16:0] FIELD_MAX = 17'h1FFFF;
    localparam logic [16:0] FIRST_SAMPLE = 17'd9;
    localparam logic [13:0] FULL_SCALE = 14'd10000;

    function automatic logic is_base(input logic [7:0] b);
        return b == 8'h41 || b == 8'h43 || b == 8'h47 || b == 8'h54;
    endfunction

    function automatic logic [7:0] pass_char(input logic [1:0] i);
        case (i)
            2'd0: pass_char = 8'h50;
            2'd1: pass_char = 8'h41;
            2'd2: pass_char = 8'h53;
            default: pass_char = 8'h53;
        endcase
    endfunction

endpackage

### hw/rtl/vrff_parse.sv
// Front: byte parser. Produces one line record per finished data line.
module vrff_parse #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  vrff_pkg::t_in_item     i_item,
    input  logic [15:0]            i_chrom,
    output logic                   o_valid,
    output logic                   o_ok,
    output logic [SAMPLE_BITS-1:0] o_carriers,
    output logic [SAMPLE_BITS-1:0] o_samples
);
    localparam logic [SAMPLE_BITS:0]   COL_MAX = '1;
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = '1;

    logic [2:0]             r_phase, n_phase;
    logic [16:0]            r_field, n_field;
    logic [2:0]             r_pos, n_pos;
    logic                   r_ok, n_ok;
    logic [SAMPLE_BITS:0]   r_cols, n_cols;
    logic [SAMPLE_BITS-1:0] r_carr, n_carr;
    logic                   r_nonref, n_nonref;
    logic                   r_ovalid, n_ovalid;
    logic                   r_ook;
    logic [SAMPLE_BITS-1:0] r_ocarr, r_osmp;

    logic [7:0] b;
    logic       nl, fin;
    logic [SAMPLE_BITS:0] smp_w;
    logic [SAMPLE_BITS-1:0] smp;

    assign b  = i_item.data_byte;
    assign nl = b == vrff_pkg::CH_NL;

    always_comb begin
        smp_w = (r_cols >= (SAMPLE_BITS+1)'(9)) ? r_cols - (SAMPLE_BITS+1)'(9) : '0;
        smp   = smp_w[SAMPLE_BITS] ? SMP_MAX : smp_w[SAMPLE_BITS-1:0];
    end

    always_comb begin
        n_phase = r_phase; n_field = r_field; n_pos = r_pos; n_ok = r_ok;
        n_cols = r_cols; n_carr = r_carr; n_nonref = r_nonref;
        fin = 1'b0;
        if (i_valid) begin
            case (r_phase)
                vrff_pkg::PH_START: begin
                    if (b == vrff_pkg::CH_HASH) begin
                        n_phase = vrff_pkg::PH_HASH;
                    end else if (!nl) begin
                        n_phase = vrff_pkg::PH_DATA;
                        n_field = '0; n_pos = '0; n_ok = 1'b1;
                        n_carr = '0; n_nonref = 1'b0;
                    end
                end
                vrff_pkg::PH_HASH: begin
                    if (b == vrff_pkg::CH_HASH) begin
                        n_phase = vrff_pkg::PH_COMMENT;
                    end else begin
                        n_cols = '0; n_pos = '0;
                        n_phase = nl ? vrff_pkg::PH_START : vrff_pkg::PH_HEADER;
                    end
                end
                vrff_pkg::PH_COMMENT: begin
                    if (nl) n_phase = vrff_pkg::PH_START;
                end
                vrff_pkg::PH_HEADER: begin
                    if (nl) begin
                        n_phase = vrff_pkg::PH_START; n_pos = '0;
                    end
                end
                default: begin
                    if (nl) fin = 1'b1;
                end
            endcase
            // header token counting (PH_HASH non-hash non-nl, or PH_HEADER non-nl)
            if ((r_phase == vrff_pkg::PH_HASH && b != vrff_pkg::CH_HASH && !nl) ||
                (r_phase == vrff_pkg::PH_HEADER && !nl)) begin
                if (b == vrff_pkg::CH_SPACE || b == vrff_pkg::CH_TAB) begin
                    n_pos = '0;
                end else if (n_pos == 3'd0) begin
                    n_pos = 3'd1;
                    if (n_cols < COL_MAX) n_cols = n_cols + 1'b1;
                end
            end
            // data byte or line finish
            if ((r_phase == vrff_pkg::PH_START && !nl && b != vrff_pkg::CH_HASH) ||
                (r_phase == vrff_pkg::PH_DATA)) begin
                if (b == vrff_pkg::CH_TAB || fin) begin
                    if (n_field == 17'd0) begin
                        if (n_pos < 3'd2) n_ok = 1'b0;
                    end else if (n_field == 17'd3 || n_field == 17'd4) begin
                        if (n_pos != 3'd1) n_ok = 1'b0;
                    end else if (n_field == 17'd6) begin
                        if (n_pos < 3'd4) n_ok = 1'b0;
                    end else if (n_field >= vrff_pkg::FIRST_SAMPLE && n_pos != 3'd0) begin
                        if ((n_nonref || n_pos < 3'd3) && n_carr < SMP_MAX)
                            n_carr = n_carr + 1'b1;
                    end
                    if (!fin) begin
                        if (n_field < vrff_pkg::FIELD_MAX) n_field = n_field + 1'b1;
                        n_pos = '0; n_nonref = 1'b0;
                    end
                end else if (n_field == 17'd4) begin
                    if (n_pos == 3'd0) begin
                        if (!vrff_pkg::is_base(b)) n_ok = 1'b0;
                        n_pos = 3'd1;
                    end else begin
                        if (b != vrff_pkg::CH_COMMA) n_ok = 1'b0;
                        n_pos = 3'd0;
                    end
                end else begin
                    if (n_field == 17'd0) begin
                        if (n_pos == 3'd0 && b != i_chrom[15:8]) n_ok = 1'b0;
                        if (n_pos == 3'd1 && b != i_chrom[7:0]) n_ok = 1'b0;
                    end else if (n_field == 17'd3) begin
                        if (n_pos == 3'd0 && !vrff_pkg::is_base(b)) n_ok = 1'b0;
                        if (n_pos >= 3'd1) n_ok = 1'b0;
                    end else if (n_field == 17'd6) begin
                        if (n_pos < 3'd4 && b != vrff_pkg::pass_char(n_pos[1:0])) n_ok = 1'b0;
                    end else if (n_field >= vrff_pkg::FIRST_SAMPLE) begin
                        if ((n_pos == 3'd0 || n_pos == 3'd2) && b != vrff_pkg::CH_ZERO)
                            n_nonref = 1'b1;
                    end
                    if (n_pos < 3'd7) n_pos = n_pos + 1'b1;
                end
            end
            if (i_item.end_of_stream) begin
                if (n_phase == vrff_pkg::PH_DATA && !fin) begin
                    fin = 1'b1;
                    if (n_field == 17'd0) begin
                        if (n_pos < 3'd2) n_ok = 1'b0;
                    end else if (n_field == 17'd3 || n_field == 17'd4) begin
                        if (n_pos != 3'd1) n_ok = 1'b0;
                    end else if (n_field == 17'd6) begin
                        if (n_pos < 3'd4) n_ok = 1'b0;
                    end else if (n_field >= vrff_pkg::FIRST_SAMPLE && n_pos != 3'd0) begin
                        if ((n_nonref || n_pos < 3'd3) && n_carr < SMP_MAX)
                            n_carr = n_carr + 1'b1;
                    end
                end
                n_phase = vrff_pkg::PH_START;
                n_pos = '0;
            end
            if (fin) begin
                n_phase = vrff_pkg::PH_START;
                n_pos = '0;
            end
        end
        n_ovalid = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vrff_pkg::PH_START;
            r_field <= '0;
            r_pos <= '0;
            r_ok <= 1'b1;
            r_cols <= '0;
            r_carr <= '0;
            r_nonref <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_field <= n_field;
            r_pos <= n_pos;
            r_ok <= n_ok;
            r_cols <= n_cols;
            r_carr <= n_carr;
            r_nonref <= n_nonref;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ook   <= n_ok && n_field >= vrff_pkg::FIRST_SAMPLE;
        r_ocarr <= n_carr;
        r_osmp  <= smp;
    end

    assign o_valid    = r_ovalid;
    assign o_ok       = r_ook;
    assign o_carriers = r_ocarr;
    assign o_samples  = r_osmp;
endmodule

### hw/rtl/vrff_judge.sv
// Back: percentage check and kept counter, one line record per cycle.
module vrff_judge #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_ok,
    input  logic [SAMPLE_BITS-1:0] i_carriers,
    input  logic [SAMPLE_BITS-1:0] i_samples,
    input  logic [13:0]            i_min,
    input  logic [13:0]            i_max,
    output logic                   o_valid,
    output vrff_pkg::t_out_item    o_item
);
    localparam int PW = SAMPLE_BITS + 14;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                   r_v1, r_v2;
    logic                   r_ok1;
    logic [SAMPLE_BITS-1:0] r_s1;
    logic [PW-1:0]          r_c, r_lo, r_hi;
    logic [COUNT_BITS-1:0]  r_kept, n_kept;
    logic                   keep;
    logic [COUNT_BITS+31:0] kept_ext;

    always_ff @(posedge i_clk) begin
        r_ok1 <= i_ok && (i_samples != '0);
        r_s1  <= i_samples;
        r_c   <= PW'(i_carriers) * PW'(vrff_pkg::FULL_SCALE);
        r_lo  <= PW'(i_min) * PW'(i_samples);
        r_hi  <= PW'(i_max) * PW'(i_samples);
    end

    assign keep = r_ok1 && r_lo <= r_c && r_c <= r_hi;

    always_comb begin
        n_kept = r_kept;
        if (r_v1 && keep && r_kept != CNT_MAX) n_kept = r_kept + 1'b1;
        kept_ext = {32'd0, n_kept};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_kept <= '0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_kept <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        o_item.line_kept    <= keep;
        o_item.kept_total   <= kept_ext[31:0];
        o_item.sample_total <= 16'(r_s1);
    end

    assign o_valid = r_v2;
endmodule

### hw/rtl/vrff_fifo.sv
// Result queue; accepts while the front reserves a free slot.
module vrff_fifo #(
    parameter int DEPTH_BITS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vrff_pkg::t_out_item i_item,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [DEPTH_BITS:0] o_count,
    output vrff_pkg::t_out_item o_item
);
    localparam int DEPTH = 1 << DEPTH_BITS;
    vrff_pkg::t_out_item r_mem [DEPTH];
    logic [DEPTH_BITS:0] r_wr, r_rd;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr[DEPTH_BITS-1:0]] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
        end
    end

    assign o_empty = r_wr == r_rd;
    assign o_count = r_wr - r_rd;
    assign o_item  = r_mem[r_rd[DEPTH_BITS-1:0]];
endmodule

### hw/rtl/variant_record_frequency_filter.sv
// Variant record frequency filter.
// Input: a byte stream, one byte per transfer (push while full is low).
// Output: a queue of line verdicts; read while empty is low, advance with pop.
// Config: index/data writes with valid/ready; ready is always high. Write only
// while idle (no bytes outstanding, results drained).
// Throughput: one byte per cycle while full is low.
// Path: the newline or end-of-stream byte of a data line yields its verdict on
// the result side via the parser register (loaded at the transfer), then the
// product register, the verdict register and the queue.
// Results sit in an 8-entry queue. Input full rises when the queue plus results
// in flight could reach capacity, so a stalled reader throttles input without
// losing results.
// Reset (synchronous, active low) restores register defaults, clears counters,
// the column count, and the queue.
module variant_record_frequency_filter #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  vrff_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output vrff_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    localparam int QB = 3;

    logic [15:0] r_chrom;
    logic [13:0] r_min, r_max;
    logic        acc;
    logic        p_valid, p_ok, j_valid;
    logic [SAMPLE_BITS-1:0] p_carr, p_smp;
    vrff_pkg::t_out_item j_item;
    logic [QB:0] q_count;
    logic [QB+1:0] pend;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chrom <= 16'h3232;
            r_min   <= '0;
            r_max   <= vrff_pkg::FULL_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vrff_pkg::CFG_CHROM: r_chrom <= i_cfg_data;
                vrff_pkg::CFG_MIN:   r_min <= i_cfg_data[13:0];
                vrff_pkg::CFG_MAX:   r_max <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // in flight: parser out, judge stage 1, judge out
    logic r_f1, r_f2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1 <= 1'b0;
            r_f2 <= 1'b0;
        end else begin
            r_f1 <= p_valid;
            r_f2 <= r_f1;
        end
    end

    assign pend = (QB+2)'(q_count) + (QB+2)'(p_valid) + (QB+2)'(r_f1)
                + (QB+2)'(r_f2);
    assign full = pend >= (QB+2)'((1 << QB) - 1);
    assign acc  = push && !full;

    vrff_parse #(.SAMPLE_BITS(SAMPLE_BITS)) u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_item(i_in_item),
        .i_chrom(r_chrom), .o_valid(p_valid), .o_ok(p_ok),
        .o_carriers(p_carr), .o_samples(p_smp)
    );

    vrff_judge #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_judge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(p_valid), .i_ok(p_ok),
        .i_carriers(p_carr), .i_samples(p_smp), .i_min(r_min), .i_max(r_max),
        .o_valid(j_valid), .o_item(j_item)
    );

    vrff_fifo #(.DEPTH_BITS(QB)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(j_valid), .i_item(j_item),
        .i_pop(pop), .o_empty(empty), .o_count(q_count), .o_item(o_out_item)
    );
endmodule

### verif/tb_variant_record_frequency_filter.sv
`timescale 1ns / 1ps

module tb_variant_record_frequency_filter;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    vrff_pkg::t_in_item  i_in_item;
    logic                empty;
    logic                pop;
    vrff_pkg::t_out_item o_out_item;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index;
    logic [15:0]         i_cfg_data;

    variant_record_frequency_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in_item(i_in_item),
        .empty(empty), .pop(pop), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [15:0] chrom_sel;
    logic [13:0] pct_lo;
    logic [13:0] pct_hi;
    logic [2:0]  phase;
    logic [16:0] fld;
    logic [2:0]  pos;
    logic        ok;
    logic [16:0] columns;
    logic [15:0] carriers;
    logic        nonref;
    logic [31:0] kept_cnt;

    vrff_pkg::t_out_item verdict_q[$];
    int  errors;
    bit  send_idle;
    bit  recv_idle;
    bit  hold_reader;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("FAIL variant_record_frequency_filter");
        $finish;
    end

    function automatic bit base_letter(input logic [7:0] b);
        return b == "A" || b == "C" || b == "G" || b == "T";
    endfunction

    function automatic logic [15:0] samples_now();
        if (columns < 17'd9) return 16'd0;
        if (columns - 17'd9 > 17'hFFFF) return 16'hFFFF;
        return 16'(columns - 17'd9);
    endfunction

    task automatic close_field();
        if (fld == 0) begin
            if (pos < 2) ok = 1'b0;
        end else if (fld == 3 || fld == 4) begin
            if (pos != 1) ok = 1'b0;
        end else if (fld == 6) begin
            if (pos < 4) ok = 1'b0;
        end else if (fld >= vrff_pkg::FIRST_SAMPLE && pos > 0) begin
            if ((nonref || pos < 3) && carriers != 16'hFFFF) carriers++;
        end
    endtask

    task automatic record_byte(input logic [7:0] b);
        logic [7:0] pw;
        if (b == vrff_pkg::CH_TAB) begin
            close_field();
            if (fld != vrff_pkg::FIELD_MAX) fld++;
            pos = 0;
            nonref = 0;
            return;
        end
        if (fld == 4) begin
            if (pos == 0) begin
                if (!base_letter(b)) ok = 0;
                pos = 1;
            end else begin
                if (b != vrff_pkg::CH_COMMA) ok = 0;
                pos = 0;
            end
            return;
        end
        if (fld == 0) begin
            if (pos == 0 && b != chrom_sel[15:8]) ok = 0;
            if (pos == 1 && b != chrom_sel[7:0]) ok = 0;
        end else if (fld == 3) begin
            if (pos == 0 && !base_letter(b)) ok = 0;
            if (pos >= 1) ok = 0;
        end else if (fld == 6) begin
            case (pos)
                3'd0: pw = "P";
                3'd1: pw = "A";
                default: pw = "S";
            endcase
            if (pos < 4 && b != pw) ok = 0;
        end else if (fld >= vrff_pkg::FIRST_SAMPLE) begin
            if ((pos == 0 || pos == 2) && b != vrff_pkg::CH_ZERO) nonref = 1;
        end
        if (pos < 7) pos++;
    endtask

    task automatic end_record();
        logic [15:0] s;
        logic [47:0] c;
        bit keep;
        vrff_pkg::t_out_item r;
        close_field();
        s = samples_now();
        c = 48'(carriers) * 48'd10000;
        keep = ok && fld >= vrff_pkg::FIRST_SAMPLE && s > 0 &&
               48'(pct_lo) * 48'(s) <= c && c <= 48'(pct_hi) * 48'(s);
        if (keep && kept_cnt != 32'hFFFFFFFF) kept_cnt++;
        r.line_kept = keep;
        r.kept_total = kept_cnt;
        r.sample_total = s;
        verdict_q.push_back(r);
        phase = vrff_pkg::PH_START;
        pos = 0;
    endtask

    task automatic header_char(input logic [7:0] b);
        if (b == vrff_pkg::CH_SPACE || b == vrff_pkg::CH_TAB) pos = 0;
        else if (pos == 0) begin
            pos = 1;
            if (columns != 17'h1FFFF) columns++;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input bit eos);
        bit nl;
        nl = b == vrff_pkg::CH_NL;
        case (phase)
            vrff_pkg::PH_START: begin
                if (!nl) begin
                    if (b == vrff_pkg::CH_HASH) phase = vrff_pkg::PH_HASH;
                    else begin
                        phase = vrff_pkg::PH_DATA;
                        fld = 0;
                        pos = 0;
                        ok = 1;
                        carriers = 0;
                        nonref = 0;
                        record_byte(b);
                    end
                end
            end
            vrff_pkg::PH_HASH: begin
                if (b == vrff_pkg::CH_HASH) phase = vrff_pkg::PH_COMMENT;
                else begin
                    columns = 0;
                    pos = 0;
                    if (nl) phase = vrff_pkg::PH_START;
                    else begin
                        phase = vrff_pkg::PH_HEADER;
                        header_char(b);
                    end
                end
            end
            vrff_pkg::PH_COMMENT: if (nl) phase = vrff_pkg::PH_START;
            vrff_pkg::PH_HEADER: begin
                if (nl) begin
                    phase = vrff_pkg::PH_START;
                    pos = 0;
                end else header_char(b);
            end
            default: begin
                if (nl) end_record();
                else record_byte(b);
            end
        endcase
        if (eos) begin
            if (phase == vrff_pkg::PH_DATA) end_record();
            phase = vrff_pkg::PH_START;
            pos = 0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit eos = 0);
        int gap;
        if (send_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item.data_byte <= b;
        i_in_item.end_of_stream <= eos;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_byte(b, eos);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    // result checker
    initial begin
        vrff_pkg::t_out_item e;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty && i_rst_n) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    e = verdict_q.pop_front();
                    if (o_out_item.line_kept !== e.line_kept) begin
                        $error("line_kept exp %0d got %0d", e.line_kept,
                               o_out_item.line_kept);
                        errors++;
                    end
                    if (o_out_item.kept_total !== e.kept_total) begin
                        $error("kept_total exp %0d got %0d", e.kept_total,
                               o_out_item.kept_total);
                        errors++;
                    end
                    if (o_out_item.sample_total !== e.sample_total) begin
                        $error("sample_total exp %0d got %0d", e.sample_total,
                               o_out_item.sample_total);
                        errors++;
                    end
                end
            end
            if (hold_reader) pop <= 1'b0;
            else if (recv_idle && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge i_clk);
            end else pop <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            vrff_pkg::CFG_CHROM: chrom_sel = val;
            vrff_pkg::CFG_MIN:   pct_lo = val[13:0];
            default:             pct_hi = val[13:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic string genotype_token();
        string t;
        case ($urandom_range(0, 5))
            0: t = "0|0";
            1: t = "0|1";
            2: t = "1|0";
            3: t = "1|1";
            4: t = "0";
            default: t = "0/0:5";
        endcase
        return t;
    endfunction

    function automatic string random_record(input int nsamp, input bit clean);
        string s;
        string chrom;
        chrom = "";
        chrom = {chrom, string'(chrom_sel[15:8]), string'(chrom_sel[7:0])};
        if (!clean && $urandom_range(0, 3) == 0) chrom = "1";
        s = {chrom, "\t100\trs1\t"};
        s = {s, clean || $urandom_range(0, 1) ? "A" : "AC", "\t"};
        s = {s, clean || $urandom_range(0, 1) ? "G,T" : "G,", "\t50\t"};
        s = {s, clean || $urandom_range(0, 1) ? "PASS" : "q10", "\t.\tGT"};
        for (int k = 0; k < nsamp; k++) s = {s, "\t", genotype_token()};
        return s;
    endfunction

    task automatic test_directed();
        send_text("##fileformat\n");
        send_text("#CHROM POS ID REF ALT QUAL FILTER INFO FORMAT s1\ts2\ts3 s4\n");
        send_text("\n");
        send_text("22\t1\t.\tA\tC,G,T\t9\tPASS\t.\tGT\t0|0\t1|0\t0|1\t\t0\n");
        send_text("22\t1\t.\tN\tC\t9\tPASS\t.\tGT\t0|0\n");
        send_text("22\t1\t.\tA\t\t9\tPASS\t.\tGT\t0|0\n");
        send_text("2\t1\t.\tA\tC\t9\tPASS\n");
        send_byte(8'hFF);
        send_byte(8'h00, 1);
        send_text("22\t1\t.\tT\tA\t.\tPASSX\t.\tGT\t1|1");
        send_byte("\t", 1);
        send_text("#\n");
        send_text("22\t1\t.\tA\tC\t9\tPASS\t.\tGT\t0|0\n");
        drain();
    endtask

    task automatic test_bounds();
        write_reg(vrff_pkg::CFG_CHROM, 16'h5831);
        write_reg(vrff_pkg::CFG_MIN, 16'd5000);
        write_reg(vrff_pkg::CFG_MAX, 16'd5000);
        send_text("#a b c d e f g h i s1 s2\n");
        send_text("X1\t1\t.\tG\tA\t.\tPASS\t.\tGT\t0|1\t0|0\n");
        send_text("X1\t1\t.\tG\tA\t.\tPASS\t.\tGT\t0|1\t1|0\n");
        drain();
        write_reg(vrff_pkg::CFG_MIN, 16'd10000);
        write_reg(vrff_pkg::CFG_MAX, 16'd0);
        send_text("X1\t1\t.\tG\tA\t.\tPASS\t.\tGT\t0|1\t1|0\n");
        drain();
        write_reg(vrff_pkg::CFG_MIN, 16'd0);
        write_reg(vrff_pkg::CFG_MAX, 16'd10000);
        write_reg(vrff_pkg::CFG_CHROM, 16'h3232);
        drain();
    endtask

    task automatic test_random(input int nbytes);
        int sent;
        string s;
        int ns;
        sent = 0;
        while (sent < nbytes) begin
            case ($urandom_range(0, 9))
                0: begin
                    ns = $urandom_range(0, 6);
                    s = "#C P I R A Q F I F";
                    for (int k = 0; k < ns; k++) s = {s, "\tS"};
                    s = {s, "\n"};
                end
                1: s = "##meta\n";
                2: begin
                    s = "";
                    for (int k = 0; k < $urandom_range(1, 12); k++)
                        s = {s, string'(8'($urandom_range(0, 255)))};
                end
                default: s = {random_record($urandom_range(0, 6),
                                            $urandom_range(0, 2) != 0), "\n"};
            endcase
            if ($urandom_range(0, 15) == 0) begin
                send_text(s.substr(0, s.len() - 2));
                send_byte(s[s.len() - 1], 1);
            end else send_text(s);
            sent += s.len();
        end
    endtask

    task automatic test_backpressure();
        hold_reader = 1;
        fork
            begin
                for (int k = 0; k < 10; k++)
                    send_text("22\t1\t.\tA\tC\t9\tPASS\t.\tGT\t1|1\n");
                push <= 1'b0;
                @(posedge i_clk);
            end
            begin
                repeat (600) @(posedge i_clk);
                hold_reader = 0;
            end
        join
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(vrff_pkg::CFG_CHROM, 16'hFFFF);
        write_reg(vrff_pkg::CFG_MIN, 16'h3FFF);
        send_text("22\t1\t.\tA\tC\t9\tPASS\t.\tGT\t1|1\n");
        drain();
        write_reg(vrff_pkg::CFG_CHROM, 16'h0000);
        write_reg(vrff_pkg::CFG_MIN, 16'd2500);
        write_reg(vrff_pkg::CFG_MAX, 16'd7500);
        send_text("#a b c d e f g h i s1 s2 s3 s4\n");
        test_random(100);
        drain();
        write_reg(vrff_pkg::CFG_CHROM, 16'h3232);
        write_reg(vrff_pkg::CFG_MIN, 16'd0);
        write_reg(vrff_pkg::CFG_MAX, 16'd10000);
    endtask

    initial begin
        errors = 0;
        send_idle = 1;
        recv_idle = 1;
        hold_reader = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vrff_pkg::CFG_CHROM;
        i_cfg_data = '0;
        chrom_sel = 16'h3232;
        pct_lo = 14'd0;
        pct_hi = 14'd10000;
        phase = vrff_pkg::PH_START;
        fld = 0;
        pos = 0;
        ok = 1;
        columns = 0;
        carriers = 0;
        nonref = 0;
        kept_cnt = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_bounds();
        test_backpressure();
        test_random(120);
        drain();
        test_config_sweep();
        send_idle = 0;
        recv_idle = 0;
        test_random(150);

        push <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS variant_record_frequency_filter");
        end else begin
            $display("FAIL variant_record_frequency_filter");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/vrff_pkg.sv
hw/rtl/vrff_parse.sv
hw/rtl/vrff_judge.sv
hw/rtl/vrff_fifo.sv
hw/rtl/variant_record_frequency_filter.sv
verif/tb_variant_record_frequency_filter.sv
